// ----- sv/key_debounce_hold_repeat_core_defines.svh -----
// ----------------------------------------------------------------------------
// Key debounce core assertion macros
// Shared concurrent assertion shorthands, clocked on clk, reset by arst_n.
// ----------------------------------------------------------------------------
`ifndef KEY_DEBOUNCE_HOLD_REPEAT_CORE_DEFINES_SVH
`define KEY_DEBOUNCE_HOLD_REPEAT_CORE_DEFINES_SVH

// same-cycle implication
`define KDHR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define KDHR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/kdhr_pkg.sv -----
// ----------------------------------------------------------------------------
// Key debounce package
// Request/event payloads, config record, event and register codes.
// ----------------------------------------------------------------------------
package kdhr_pkg;

	localparam int PORT_W      = 8;
	localparam int FIELD_TIME_W = 32;
	localparam int TICKS_W     = 16;
	localparam int KEY_IDX_W   = 3;
	localparam int KIND_W      = 3;
	localparam int CFG_IDX_W   = 3;
	localparam int MAX_EVENTS  = 32;
	localparam int CNT_W       = $clog2(MAX_EVENTS + 1);

	// event kinds; also the bit positions in a cell's event mask
	localparam logic [KIND_W-1:0] EV_DOWN   = 3'd0;
	localparam logic [KIND_W-1:0] EV_PRESS  = 3'd1;
	localparam logic [KIND_W-1:0] EV_UP     = 3'd2;
	localparam logic [KIND_W-1:0] EV_HOLD   = 3'd3;
	localparam logic [KIND_W-1:0] EV_REPEAT = 3'd4;
	localparam int EV_COUNT = 5;

	// config register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD         = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT_START = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT_PER   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_EVENTS_EN    = 3'd4;

	localparam logic [TICKS_W-1:0] DEBOUNCE_RST     = 16'd20;
	localparam logic [TICKS_W-1:0] HOLD_RST         = 16'd500;
	localparam logic [TICKS_W-1:0] REPEAT_START_RST = 16'd500;
	localparam logic [TICKS_W-1:0] REPEAT_PER_RST   = 16'd100;

	typedef logic [EV_COUNT-1:0] kdhr_mask_t;

	typedef struct packed {
		logic                    opcode;
		logic [PORT_W-1:0]       port_bits;
		logic [FIELD_TIME_W-1:0] sample_time;
		logic [FIELD_TIME_W-1:0] now_time;
	} kdhr_req_t;

	typedef struct packed {
		logic [KEY_IDX_W-1:0] key_index;
		logic [KIND_W-1:0]    event_kind;
		logic                 last_event;
	} kdhr_evt_t;

	typedef struct packed {
		logic [TICKS_W-1:0] debounce_ticks;
		logic [TICKS_W-1:0] hold_ticks;
		logic [TICKS_W-1:0] repeat_start_ticks;
		logic [TICKS_W-1:0] repeat_period_ticks;
		logic               events_enabled;
	} kdhr_cfg_t;

	// chain control; load and shift are broadcast to every cell
	typedef struct packed {
		logic load;  // evaluate the request, load event mask
		logic shift; // take neighbor's mask
		logic pop;   // drop lowest pending event (head only)
	} kdhr_cell_ctl_t;

endpackage

// ----- sv/key_debounce_hold_repeat_core.sv -----
// ----------------------------------------------------------------------------
// Key debounce, hold and auto-repeat core
// Debounces up to NUM_KEYS keys and reports down/press/up/hold/repeat events.
// ----------------------------------------------------------------------------
// Flow: an accepted request loads every cell's event mask; the head key's first event
//   then goes to the output register once the leading eventless keys have shifted out.
// A new request is taken only when the previous one is done; the chain drains one event
//   or one empty key per cycle while the event sink is not stalling.
// Reset: arst_n clears all key state, the event chain and the output valid flag, and
//   loads the timing registers with their defaults (events disabled).
// ----------------------------------------------------------------------------
`include "key_debounce_hold_repeat_core_defines.svh"

module key_debounce_hold_repeat_core
	import kdhr_pkg::*;
#(
	parameter int NUM_KEYS  = 8,
	parameter int TIME_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// request channel
	input  logic                 req_valid,
	output logic                 req_ready,
	input  kdhr_req_t            req,
	// event channel
	output logic                 evt_valid,
	input  logic                 evt_ready,
	output kdhr_evt_t            evt,
	// config write channel
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [TICKS_W-1:0]   cfg_data
);

	localparam int KW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

	// ------------------------------------------------------------------
	// Config registers; the block does not enforce it, but they are to be written only while the core is idle
	// ------------------------------------------------------------------
	kdhr_cfg_t cfg_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ticks      <= DEBOUNCE_RST;
			cfg_q.hold_ticks          <= HOLD_RST;
			cfg_q.repeat_start_ticks  <= REPEAT_START_RST;
			cfg_q.repeat_period_ticks <= REPEAT_PER_RST;
			cfg_q.events_enabled      <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_DEBOUNCE:     cfg_q.debounce_ticks      <= cfg_data;
				REG_HOLD:         cfg_q.hold_ticks          <= cfg_data;
				REG_REPEAT_START: cfg_q.repeat_start_ticks  <= cfg_data;
				REG_REPEAT_PER:   cfg_q.repeat_period_ticks <= cfg_data;
				REG_EVENTS_EN:    cfg_q.events_enabled      <= cfg_data[0];
				default:          ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Sequencer state
	// busy_q : a request's events are still draining out of the chain
	// pos_q  : key number of the head cell
	// cnt_q  : events sent for this request (capped at MAX_EVENTS)
	// ------------------------------------------------------------------
	logic             busy_q;
	logic [KW-1:0]    pos_q;
	logic [CNT_W-1:0] cnt_q;
	logic             evt_valid_q;
	kdhr_evt_t        evt_q;

	logic           accept;
	kdhr_cell_ctl_t ctl;
	kdhr_mask_t     masks [NUM_KEYS];
	kdhr_mask_t     head;
	logic           head_any, head_one, rest_any, out_free, emit, last;
	logic [KIND_W-1:0] kind;

	assign req_ready = !busy_q;
	assign accept    = req_valid && req_ready;

	// ------------------------------------------------------------------
	// Cell chain: all keys evaluate in parallel on accept; afterwards the
	// pending event masks move one cell toward the head per shift.
	// ------------------------------------------------------------------
	for (genvar k = 0; k < NUM_KEYS; k++) begin : g_cell
		logic       raw_bit;
		kdhr_mask_t nb_mask;

		if (k < PORT_W) begin : g_port
			assign raw_bit = req.port_bits[k];
		end else begin : g_noport
			assign raw_bit = 1'b0; // keys past the port read low
		end

		if (k < NUM_KEYS - 1) begin : g_nb
			assign nb_mask = masks[k+1];
		end else begin : g_tail
			assign nb_mask = '0;
		end

		kdhr_cell #(
			.TIME_BITS(TIME_BITS)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (kdhr_cell_ctl_t'{load: ctl.load, shift: ctl.shift,
			                              pop: ctl.pop && (k == 0)}),
			.cfg        (cfg_q),
			.sample     (req.opcode),
			.raw_bit    (raw_bit),
			.sample_time(req.sample_time[TIME_BITS-1:0]),
			.now_time   (req.now_time[TIME_BITS-1:0]),
			.mask_in    (nb_mask),
			.mask       (masks[k])
		);
	end

	// ------------------------------------------------------------------
	// Head decode: lowest pending bit is the next event of the head key
	// ------------------------------------------------------------------
	always_comb begin
		head     = masks[0];
		head_any = |head;
		head_one = head_any && ((head & (head - kdhr_mask_t'(1))) == '0);
		rest_any = 1'b0;
		for (int k = 1; k < NUM_KEYS; k++) begin
			rest_any = rest_any || (|masks[k]);
		end

		priority if (head[EV_DOWN])  kind = EV_DOWN;
		else if (head[EV_PRESS])     kind = EV_PRESS;
		else if (head[EV_UP])        kind = EV_UP;
		else if (head[EV_HOLD])      kind = EV_HOLD;
		else                         kind = EV_REPEAT;
	end

	assign out_free = !evt_valid_q || evt_ready;
	assign emit     = busy_q && head_any && out_free;
	// final event: nothing left behind it, or the per-request cap is hit
	assign last     = (head_one && !rest_any) || (cnt_q == CNT_W'(MAX_EVENTS - 1));

	always_comb begin
		ctl.load  = accept;
		ctl.pop   = emit;
		// advance when the head key is done: its last event goes out this
		// cycle, or it had none and later keys still hold events
		ctl.shift = busy_q && ((emit && head_one) || (!head_any && rest_any));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pos_q  <= '0;
			cnt_q  <= '0;
		end else if (accept) begin
			busy_q <= 1'b1;
			pos_q  <= '0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			if (emit) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (ctl.shift) begin
				pos_q <= pos_q + KW'(1);
			end
			if ((emit && last) || (!head_any && !rest_any)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Output register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			evt_valid_q <= 1'b0;
		end else if (emit) begin
			evt_valid_q <= 1'b1;
		end else if (evt_ready) begin
			evt_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			evt_q.key_index  <= KEY_IDX_W'(pos_q);
			evt_q.event_kind <= kind;
			evt_q.last_event <= last;
		end
	end

	assign evt_valid = evt_valid_q;
	assign evt       = evt_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	`KDHR_ASSERT_NOW(a_cnt_cap, busy_q, cnt_q < CNT_W'(MAX_EVENTS), "event count past cap")
	`KDHR_ASSERT_NEXT(a_last_ends, emit && last, !busy_q, "busy after final event")
	`KDHR_ASSERT_NOW(a_emit_enabled, emit, cfg_q.events_enabled, "event while disabled")

endmodule

// ----- sv/kdhr_cell.sv -----
// ----------------------------------------------------------------------------
// Key debounce cell
// Per-key state; evaluates one request and holds the key's pending events.
// ----------------------------------------------------------------------------
module kdhr_cell
	import kdhr_pkg::*;
#(
	parameter int TIME_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  kdhr_cell_ctl_t       ctl,
	input  kdhr_cfg_t            cfg,
	input  logic                 sample,
	input  logic                 raw_bit,
	input  logic [TIME_BITS-1:0] sample_time,
	input  logic [TIME_BITS-1:0] now_time,
	input  kdhr_mask_t           mask_in,
	output kdhr_mask_t           mask
);

	localparam int CW = (TIME_BITS > TICKS_W) ? TIME_BITS : TICKS_W;

	logic                 raw_q, deb_q, hold_q;
	logic [TIME_BITS-1:0] raw_time_q, press_time_q, rep_time_q;
	kdhr_mask_t           mask_q;

	logic                 raw_n, deb_n, hold_mid, hold_n;
	logic [TIME_BITS-1:0] raw_time_n, press_time_n, rep_time_n;
	logic [TIME_BITS-1:0] el_raw, el_press, el_rep;
	logic                 press_edge, release_ok, hold_ev, rep_ev;
	kdhr_mask_t           mask_n;

	always_comb begin
		raw_n      = sample ? raw_bit : raw_q;
		raw_time_n = sample ? sample_time : raw_time_q;
		el_raw     = now_time - raw_time_n;

		press_edge = raw_n && !deb_q;
		release_ok = !raw_n && deb_q &&
			(CW'(el_raw) >= CW'(cfg.debounce_ticks));

		deb_n        = press_edge ? 1'b1 : (release_ok ? 1'b0 : deb_q);
		press_time_n = press_edge ? raw_time_n : press_time_q;
		hold_mid     = press_edge ? 1'b0 : hold_q;
		el_press     = now_time - press_time_n;
		el_rep       = now_time - rep_time_q;

		hold_ev = deb_n && !hold_mid && (CW'(el_press) >= CW'(cfg.hold_ticks));
		hold_n  = hold_mid || hold_ev;

		rep_ev = deb_n && (CW'(el_press) >= CW'(cfg.repeat_start_ticks)) &&
			(CW'(el_rep) >= CW'(cfg.repeat_period_ticks));
		rep_time_n = rep_ev ? now_time : rep_time_q;

		mask_n            = '0;
		mask_n[EV_DOWN]   = press_edge;
		mask_n[EV_PRESS]  = press_edge;
		mask_n[EV_UP]     = release_ok;
		mask_n[EV_HOLD]   = hold_ev;
		mask_n[EV_REPEAT] = rep_ev;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_q        <= 1'b0;
			deb_q        <= 1'b0;
			hold_q       <= 1'b0;
			raw_time_q   <= '0;
			press_time_q <= '0;
			rep_time_q   <= '0;
			mask_q       <= '0;
		end else if (ctl.load) begin
			raw_q        <= raw_n;
			deb_q        <= deb_n;
			hold_q       <= hold_n;
			raw_time_q   <= raw_time_n;
			press_time_q <= press_time_n;
			rep_time_q   <= rep_time_n;
			mask_q       <= cfg.events_enabled ? mask_n : '0;
		end else if (ctl.shift) begin
			mask_q <= mask_in;
		end else if (ctl.pop) begin
			mask_q <= mask_q & (mask_q - kdhr_mask_t'(1));
		end
	end

	assign mask = mask_q;

endmodule
